/* rtl/sierpinski_carpet_pixel_color_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Sierpinski carpet pixel color unit
// Shared concurrent-assertion shorthands, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef SIERPINSKI_CARPET_PIXEL_COLOR_UNIT_MACROS_SVH
`define SIERPINSKI_CARPET_PIXEL_COLOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SCPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scpc same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define SCPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scpc next-cycle check failed");

`endif

/* rtl/scpc_pkg.sv */
// ----------------------------------------------------------------------------
// Sierpinski carpet pixel color package
// Widths, reset values, the color type and the nine-entry palette.
// ----------------------------------------------------------------------------
package scpc_pkg;

  // Fixed field widths.
  localparam int COORD_W = 12;
  localparam int CHAN_W  = 8;
  localparam int CFG_W   = 3;

  // Default deepest carpet order and the order after reset.
  localparam int              MAX_ORDER_DEF = 7;
  localparam logic [CFG_W-1:0] ORDER_RESET  = 3'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Evaluated pixel, handed from the evaluator to the result register.
  typedef struct packed {
    rgb_t color;
    logic out_of_range;
  } pixel_t;

  localparam rgb_t BLACK = '{red: 8'd0, green: 8'd0, blue: 8'd0};

  // Palette indexed by 3*top_y + top_x; the center entry is black.
  function automatic rgb_t palette_lookup(input logic [3:0] idx);
    rgb_t c;
    begin
      case (idx)
        4'd0:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
        4'd1:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
        4'd2:    c = '{red: 8'd255, green: 8'd165, blue: 8'd0};
        4'd3:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
        4'd5:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
        4'd6:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
        4'd7:    c = '{red: 8'd0,   green: 8'd128, blue: 8'd0};
        4'd8:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
        default: c = BLACK;
      endcase
      return c;
    end
  endfunction

endpackage

/* rtl/scpc_pixel_eval.sv */
// ----------------------------------------------------------------------------
// Sierpinski carpet pixel evaluator
// Combinational color and range evaluation of one registered coordinate.
// ----------------------------------------------------------------------------
module scpc_pixel_eval #(
  parameter int MAX_ORDER = scpc_pkg::MAX_ORDER_DEF,
  parameter int ORD_W     = $clog2(MAX_ORDER + 1)
) (
  input  logic [scpc_pkg::COORD_W-1:0] x_i,
  input  logic [scpc_pkg::COORD_W-1:0] y_i,
  input  logic [ORD_W-1:0]             ord_i,
  output scpc_pkg::pixel_t             pix_o
);
  import scpc_pkg::*;

  // Reciprocal scaling that makes floor(v / 3^k) exact for every coordinate.
  localparam int SHIFT  = COORD_W + $clog2(3 ** MAX_ORDER) + 1;
  localparam int PROD_W = COORD_W + SHIFT + 1;

  logic [COORD_W-1:0] qx [MAX_ORDER+1];
  logic [COORD_W-1:0] qy [MAX_ORDER+1];
  logic [MAX_ORDER-1:0] hole_at;
  logic [ORD_W-1:0]     top_pos;
  logic [1:0]           top_x;
  logic [1:0]           top_y;
  logic [3:0]           pal_idx;
  logic                 oor;
  logic                 hole;

  // Quotients by each power of three, all in parallel by constant multiply.
  for (genvar k = 0; k <= MAX_ORDER; k++) begin : g_quot
    localparam longint unsigned DIV = longint'(3 ** k);
    localparam longint unsigned MUL = ((64'd1 << SHIFT) + DIV - 1) / DIV;
    logic [PROD_W-1:0] px;
    logic [PROD_W-1:0] py;
    assign px = PROD_W'(x_i) * PROD_W'(MUL);
    assign py = PROD_W'(y_i) * PROD_W'(MUL);
    assign qx[k] = px[SHIFT +: COORD_W];
    assign qy[k] = py[SHIFT +: COORD_W];
  end

  // Base-3 digit k is q[k] - 3*q[k+1]; flag a hole where both digits are one and k is below the order.
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_digit
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    assign rx = qx[k] - (qx[k+1] + {qx[k+1][COORD_W-2:0], 1'b0});
    assign ry = qy[k] - (qy[k+1] + {qy[k+1][COORD_W-2:0], 1'b0});
    assign hole_at[k] = (ORD_W'(k) < ord_i) && (rx[1:0] == 2'd1) && (ry[1:0] == 2'd1);
  end

  // The coordinate is inside when its quotient by the side is zero.
  always_comb begin
    top_pos = ORD_W'(ord_i - 1'b1);
    oor     = (qx[ord_i] != '0) || (qy[ord_i] != '0);
    hole    = |hole_at;
    top_x   = qx[top_pos][1:0];
    top_y   = qy[top_pos][1:0];
    pal_idx = {top_y, 1'b0} + {2'b00, top_y} + {2'b00, top_x};

    pix_o.out_of_range = oor;
    if (oor || hole) begin
      pix_o.color = BLACK;
    end else begin
      pix_o.color = palette_lookup(pal_idx);
    end
  end

endmodule

/* rtl/sierpinski_carpet_pixel_color_unit.sv */
// ----------------------------------------------------------------------------
// Sierpinski carpet pixel color unit
// Test-pattern generator: one pixel coordinate in, one RGB color out.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one pixel coordinate per
//   transaction; the output channel (out_valid/out_ready) carries its color
//   and an out-of-range flag, in the same order.
//   The carpet order is written through cfg_we/cfg_pattern_order while the
//   unit is idle; orders below one act as one, above MAX_ORDER as MAX_ORDER.
//   A coordinate accepted on the input channel is loaded into the input
//   register; the result register then loads the outcome of one evaluation
//   pass of parallel constant multiplies and presents the color.
//   Throughput is one pixel per clock while the receiver does not stall.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only when both are full and out_ready
//   is low.
//   Synchronous reset empties both stages and sets the order to three.
// ----------------------------------------------------------------------------
module sierpinski_carpet_pixel_color_unit #(
  parameter int MAX_ORDER = scpc_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [scpc_pkg::CFG_W-1:0]  cfg_pattern_order,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scpc_pkg::COORD_W-1:0] in_x_coord,
  input  logic [scpc_pkg::COORD_W-1:0] in_y_coord,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [scpc_pkg::CHAN_W-1:0] out_red,
  output logic [scpc_pkg::CHAN_W-1:0] out_green,
  output logic [scpc_pkg::CHAN_W-1:0] out_blue,
  output logic                        out_out_of_range
);
  import scpc_pkg::*;
  `include "sierpinski_carpet_pixel_color_unit_macros.svh"

  localparam int ORD_W = $clog2(MAX_ORDER + 1);

  logic [CFG_W-1:0]   order_r;
  logic [ORD_W-1:0]   ord_eff;
  logic               s1_valid_r;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic               out_valid_r;
  pixel_t             pix_r;
  pixel_t             pix_nxt;
  logic               out_load;
  logic               s1_adv;
  logic               in_acc;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (cfg_we) begin
      order_r <= cfg_pattern_order;
    end
  end

  // Clamp the order into the supported range.
  always_comb begin
    if (order_r == '0) begin
      ord_eff = ORD_W'(1);
    end else if (int'(order_r) > MAX_ORDER) begin
      ord_eff = ORD_W'(MAX_ORDER);
    end else begin
      ord_eff = ORD_W'(order_r);
    end
  end

  // Pipeline flow control.
  assign out_load = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;
  assign in_acc   = in_valid && in_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_x_coord;
      y_r <= in_y_coord;
    end
  end

  // Evaluation of the registered coordinate.
  scpc_pixel_eval #(
    .MAX_ORDER (MAX_ORDER),
    .ORD_W     (ORD_W)
  ) u_eval (
    .x_i   (x_r),
    .y_i   (y_r),
    .ord_i (ord_eff),
    .pix_o (pix_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = pix_r.color.red;
  assign out_green        = pix_r.color.green;
  assign out_blue         = pix_r.color.blue;
  assign out_out_of_range = pix_r.out_of_range;

  // An out-of-range pixel is always black.
  `SCPC_ASSERT_NOW(a_oor_black, out_valid_r && pix_r.out_of_range, pix_r.color == BLACK)
  // An accepted transaction occupies the input register next cycle.
  `SCPC_ASSERT_NEXT(a_accept_fills, in_acc, s1_valid_r)
  // A result appears only after the input register handed one over.
  `SCPC_ASSERT_NOW(a_out_from_s1, $rose(out_valid_r), $past(s1_adv))

endmodule
